// ===== rtl/core/http_request_byte_tokenizer_macros.svh =====
// assertion helpers for the tokenizer rtl
`ifndef HTTP_REQUEST_BYTE_TOKENIZER_MACROS_SVH
`define HTTP_REQUEST_BYTE_TOKENIZER_MACROS_SVH

// clocked check, masked while reset is asserted
`define HRBT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define HRBT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/hrbt_pkg.sv =====
package hrbt_pkg;

    // default saturation point of the header counter
    localparam int unsigned HEADER_COUNT_MAX_DEF = 255;

    // bytes skipped between the uri and the version
    localparam int unsigned PREFIX_LEN = 5;

    // characters the parser looks for
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // parse phases
    typedef enum logic [3:0] {
        PH_LEAD,
        PH_METHOD,
        PH_SEP1,
        PH_URI,
        PH_SEP2,
        PH_PREFIX,
        PH_VSTART,
        PH_VERSION,
        PH_LINE_LF,
        PH_LINE_START,
        PH_NAME,
        PH_HSEP,
        PH_VALUE,
        PH_END_LF,
        PH_BODY_FIRST,
        PH_BODY
    } t_phase;

    // byte tags
    typedef enum logic [2:0] {
        CL_SKIP    = 3'd0,
        CL_METHOD  = 3'd1,
        CL_URI     = 3'd2,
        CL_VERSION = 3'd3,
        CL_NAME    = 3'd4,
        CL_VALUE   = 3'd5,
        CL_EOL     = 3'd6,
        CL_BODY    = 3'd7
    } t_byte_class;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] prefix_left;
        logic [7:0] header_count;
    } t_parse_state;

    typedef struct packed {
        t_byte_class byte_class;
        logic        token_first;
    } t_byte_tag;

    localparam t_parse_state PARSE_STATE_RST = '{
        phase:        PH_LEAD,
        prefix_left:  3'd0,
        header_count: 8'd0
    };

endpackage

// ===== rtl/core/hrbt_classify.sv =====
module hrbt_classify #(
    parameter int unsigned HEADER_COUNT_MAX = hrbt_pkg::HEADER_COUNT_MAX_DEF
) (
    input  hrbt_pkg::t_parse_state i_state,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_new_request,
    output hrbt_pkg::t_parse_state o_state,
    output hrbt_pkg::t_byte_tag    o_tag
);

    localparam int unsigned CAP_INT   = (HEADER_COUNT_MAX < 255) ? HEADER_COUNT_MAX : 255;
    localparam logic [7:0]  COUNT_CAP = CAP_INT[7:0];
    localparam logic [2:0]  PREFIX_INIT = 3'((hrbt_pkg::PREFIX_LEN - 1) & 7);

    hrbt_pkg::t_parse_state st;
    logic                   is_cr;
    logic                   is_lf;
    logic                   is_colon;
    logic                   is_blank;
    logic [7:0]             cnt_inc;
    logic [2:0]             prefix_dec;

    // line start handling, shared by two phases
    hrbt_pkg::t_phase       ls_phase;
    hrbt_pkg::t_byte_class  ls_class;
    logic                   ls_first;
    logic [7:0]             ls_count;

    // a new request restarts from the reset state with this byte
    assign st = i_new_request ? hrbt_pkg::PARSE_STATE_RST : i_state;

    assign is_cr    = (i_data_byte == hrbt_pkg::CH_CR);
    assign is_lf    = (i_data_byte == hrbt_pkg::CH_LF);
    assign is_colon = (i_data_byte == hrbt_pkg::CH_COLON);
    assign is_blank = (i_data_byte == hrbt_pkg::CH_SP) || (i_data_byte == hrbt_pkg::CH_TAB);

    // saturating header count
    assign cnt_inc    = (st.header_count < COUNT_CAP) ? st.header_count + 8'd1
                                                      : st.header_count;
    assign prefix_dec = st.prefix_left - 3'd1;

    // first byte of a header line or of the blank line ending the headers
    always_comb begin
        if (is_cr) begin
            ls_phase = hrbt_pkg::PH_END_LF;
            ls_class = hrbt_pkg::CL_EOL;
            ls_first = 1'b0;
            ls_count = st.header_count;
        end else if (is_colon) begin
            ls_phase = hrbt_pkg::PH_HSEP;
            ls_class = hrbt_pkg::CL_SKIP;
            ls_first = 1'b0;
            ls_count = cnt_inc;
        end else begin
            ls_phase = hrbt_pkg::PH_NAME;
            ls_class = hrbt_pkg::CL_NAME;
            ls_first = 1'b1;
            ls_count = cnt_inc;
        end
    end

    // phase transitions and byte tag
    always_comb begin
        o_state           = st;
        o_tag.byte_class  = hrbt_pkg::CL_SKIP;
        o_tag.token_first = 1'b0;
        unique case (st.phase)
            hrbt_pkg::PH_LEAD: begin
                if (is_cr || is_lf) begin
                    o_tag.byte_class = hrbt_pkg::CL_SKIP;
                end else if (is_blank) begin
                    o_state.phase = hrbt_pkg::PH_SEP1;
                end else begin
                    o_tag.byte_class  = hrbt_pkg::CL_METHOD;
                    o_tag.token_first = 1'b1;
                    o_state.phase     = hrbt_pkg::PH_METHOD;
                end
            end
            hrbt_pkg::PH_METHOD: begin
                if (is_blank) o_state.phase = hrbt_pkg::PH_SEP1;
                else          o_tag.byte_class = hrbt_pkg::CL_METHOD;
            end
            hrbt_pkg::PH_SEP1: begin
                if (!is_blank) begin
                    o_tag.byte_class  = hrbt_pkg::CL_URI;
                    o_tag.token_first = 1'b1;
                    o_state.phase     = hrbt_pkg::PH_URI;
                end
            end
            hrbt_pkg::PH_URI: begin
                if (is_blank) o_state.phase = hrbt_pkg::PH_SEP2;
                else          o_tag.byte_class = hrbt_pkg::CL_URI;
            end
            hrbt_pkg::PH_SEP2: begin
                // first non-blank is the first skipped prefix byte
                if (!is_blank) begin
                    o_state.prefix_left = PREFIX_INIT;
                    o_state.phase = (PREFIX_INIT == 3'd0) ? hrbt_pkg::PH_VSTART
                                                          : hrbt_pkg::PH_PREFIX;
                end
            end
            hrbt_pkg::PH_PREFIX: begin
                o_state.prefix_left = prefix_dec;
                if (prefix_dec == 3'd0) o_state.phase = hrbt_pkg::PH_VSTART;
            end
            hrbt_pkg::PH_VSTART: begin
                if (is_cr) begin
                    o_tag.byte_class = hrbt_pkg::CL_EOL;
                    o_state.phase    = hrbt_pkg::PH_LINE_LF;
                end else begin
                    o_tag.byte_class  = hrbt_pkg::CL_VERSION;
                    o_tag.token_first = 1'b1;
                    o_state.phase     = hrbt_pkg::PH_VERSION;
                end
            end
            hrbt_pkg::PH_VERSION: begin
                if (is_cr) begin
                    o_tag.byte_class = hrbt_pkg::CL_EOL;
                    o_state.phase    = hrbt_pkg::PH_LINE_LF;
                end else begin
                    o_tag.byte_class = hrbt_pkg::CL_VERSION;
                end
            end
            hrbt_pkg::PH_LINE_LF: begin
                // lf after cr is line end, anything else starts the next line
                if (is_lf) begin
                    o_tag.byte_class = hrbt_pkg::CL_EOL;
                    o_state.phase    = hrbt_pkg::PH_LINE_START;
                end else begin
                    o_tag.byte_class     = ls_class;
                    o_tag.token_first    = ls_first;
                    o_state.phase        = ls_phase;
                    o_state.header_count = ls_count;
                end
            end
            hrbt_pkg::PH_LINE_START: begin
                o_tag.byte_class     = ls_class;
                o_tag.token_first    = ls_first;
                o_state.phase        = ls_phase;
                o_state.header_count = ls_count;
            end
            hrbt_pkg::PH_NAME: begin
                if (is_colon) o_state.phase = hrbt_pkg::PH_HSEP;
                else          o_tag.byte_class = hrbt_pkg::CL_NAME;
            end
            hrbt_pkg::PH_HSEP: begin
                if (!(is_colon || is_blank || is_cr || is_lf)) begin
                    o_tag.byte_class  = hrbt_pkg::CL_VALUE;
                    o_tag.token_first = 1'b1;
                    o_state.phase     = hrbt_pkg::PH_VALUE;
                end
            end
            hrbt_pkg::PH_VALUE: begin
                if (is_cr) begin
                    o_tag.byte_class = hrbt_pkg::CL_EOL;
                    o_state.phase    = hrbt_pkg::PH_LINE_LF;
                end else begin
                    o_tag.byte_class = hrbt_pkg::CL_VALUE;
                end
            end
            hrbt_pkg::PH_END_LF: begin
                o_tag.byte_class = hrbt_pkg::CL_EOL;
                o_state.phase    = hrbt_pkg::PH_BODY_FIRST;
            end
            hrbt_pkg::PH_BODY_FIRST: begin
                o_tag.byte_class  = hrbt_pkg::CL_BODY;
                o_tag.token_first = 1'b1;
                o_state.phase     = hrbt_pkg::PH_BODY;
            end
            hrbt_pkg::PH_BODY: begin
                o_tag.byte_class = hrbt_pkg::CL_BODY;
            end
        endcase
    end

endmodule

// ===== rtl/core/http_request_byte_tokenizer.sv =====
// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+------------------------------------
// input   | in        | i_in_valid / o_in_stall    | i_data_byte, i_new_request
// output  | out       | o_out_valid / i_out_stall  | o_out_byte, o_byte_class,
//         |           |                            | o_token_first, o_header_number
//
// one item per cycle sustained while the output is not stalled; an accepted item passes
// through the input register and then the result register around the phase logic
// synchronous active-low reset returns to the leading blank phase with a zero header count
// an output stall holds the result; the input register still takes an item while the
// result register is full, and o_in_stall rises only when both registers hold items
// and the output is stalled
`include "http_request_byte_tokenizer_macros.svh"

module http_request_byte_tokenizer #(
    parameter int unsigned HEADER_COUNT_MAX = hrbt_pkg::HEADER_COUNT_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_new_request,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_byte_class,
    output logic       o_token_first,
    output logic [7:0] o_header_number
);

    localparam int unsigned CAP_INT   = (HEADER_COUNT_MAX < 255) ? HEADER_COUNT_MAX : 255;
    localparam logic [7:0]  COUNT_CAP = CAP_INT[7:0];

    logic                   r_in_vld;
    logic [7:0]             r_in_byte;
    logic                   r_in_req;
    logic                   r_out_vld;
    logic [7:0]             r_out_byte;
    hrbt_pkg::t_byte_tag    r_out_tag;
    logic [7:0]             r_out_count;
    hrbt_pkg::t_parse_state r_state;
    hrbt_pkg::t_parse_state n_state;
    hrbt_pkg::t_byte_tag    n_tag;
    logic                   out_adv;
    logic                   stage_adv;

    // pipeline flow control
    assign out_adv    = !r_out_vld || !i_out_stall;
    assign stage_adv  = r_in_vld && out_adv;
    assign o_in_stall = r_in_vld && !out_adv;

    // phase logic
    hrbt_classify #(
        .HEADER_COUNT_MAX (HEADER_COUNT_MAX)
    ) u_classify (
        .i_state       (r_state),
        .i_data_byte   (r_in_byte),
        .i_new_request (r_in_req),
        .o_state       (n_state),
        .o_tag         (n_tag)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= hrbt_pkg::PARSE_STATE_RST;
        end else begin
            if (!o_in_stall) r_in_vld <= i_in_valid;
            if (out_adv)     r_out_vld <= r_in_vld;
            if (stage_adv)   r_state <= n_state;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_req  <= i_new_request;
        end
        if (out_adv) begin
            r_out_byte  <= r_in_byte;
            r_out_tag   <= n_tag;
            r_out_count <= n_state.header_count;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_out_byte      = r_out_byte;
    assign o_byte_class    = r_out_tag.byte_class;
    assign o_token_first   = r_out_tag.token_first;
    assign o_header_number = r_out_count;

    // checks
    `HRBT_ASSERT(a_first_tagged,
        (o_out_valid && o_token_first) |->
            (o_byte_class != hrbt_pkg::CL_SKIP && o_byte_class != hrbt_pkg::CL_EOL),
        "token start on a skipped or line end item")
    `HRBT_ASSERT(a_count_cap, r_state.header_count <= COUNT_CAP, "header count above its cap")
    `HRBT_ASSERT(a_count_grows,
        (stage_adv && !r_in_req) |=>
            (r_state.header_count >= $past(r_state.header_count)),
        "header count fell without a new request")
    `HRBT_ASSERT_ALWAYS(a_stall_full,
        o_in_stall |-> (r_in_vld && r_out_vld),
        "input stalled with a free register")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import hrbt_pkg::*;

    localparam int unsigned HDR_MAX     = HEADER_COUNT_MAX_DEF;
    localparam int unsigned HDR_CAP     = (HDR_MAX < 255) ? HDR_MAX : 255;
    localparam int          RANDOM_ITEMS = 120;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 10;

    // receiver stall behaviors
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // one expected output item
    typedef struct {
        logic [7:0]  byte_val;
        t_byte_class tag;
        logic        first;
        logic [7:0]  hdr_num;
    } t_exp_tag;

    // tokenizer predictor and expected item store
    class token_scoreboard;
        t_phase     phase;
        logic [2:0] prefix_left;
        logic [7:0] hdr_count;
        t_exp_tag   expected_q[$];
        int         errors;

        function new();
            reset_parse();
            errors = 0;
        endfunction

        function void reset_parse();
            phase       = PH_LEAD;
            prefix_left = '0;
            hdr_count   = '0;
        endfunction

        function bit is_blank(input logic [7:0] b);
            return b == CH_SP || b == CH_TAB;
        endfunction

        function void bump_count();
            if (hdr_count < HDR_CAP) begin
                hdr_count = hdr_count + 8'd1;
            end
        endfunction

        // first byte of a header line or of the blank line that ends the headers
        function void start_line(input logic [7:0] b, output t_byte_class tag,
                                 output logic first);
            tag   = CL_SKIP;
            first = 1'b0;
            if (b == CH_CR) begin
                tag   = CL_EOL;
                phase = PH_END_LF;
            end else if (b == CH_COLON) begin
                bump_count();
                phase = PH_HSEP;
            end else begin
                bump_count();
                tag   = CL_NAME;
                first = 1'b1;
                phase = PH_NAME;
            end
        endfunction

        // accepted input item: advance the parse and queue the tag it gets
        function void note_item(input logic [7:0] b, input logic restart);
            t_byte_class tag;
            logic        first;
            t_exp_tag    e;
            tag   = CL_SKIP;
            first = 1'b0;
            if (restart) begin
                reset_parse();
            end
            case (phase)
                PH_LEAD: begin
                    if (!(b == CH_CR || b == CH_LF)) begin
                        if (is_blank(b)) begin
                            phase = PH_SEP1;
                        end else begin
                            tag   = CL_METHOD;
                            first = 1'b1;
                            phase = PH_METHOD;
                        end
                    end
                end
                PH_METHOD: begin
                    if (is_blank(b)) phase = PH_SEP1;
                    else tag = CL_METHOD;
                end
                PH_SEP1: begin
                    if (!is_blank(b)) begin
                        tag   = CL_URI;
                        first = 1'b1;
                        phase = PH_URI;
                    end
                end
                PH_URI: begin
                    if (is_blank(b)) phase = PH_SEP2;
                    else tag = CL_URI;
                end
                PH_SEP2: begin
                    // this byte is the first of the skipped prefix
                    if (!is_blank(b)) begin
                        prefix_left = 3'(PREFIX_LEN - 1);
                        phase = (prefix_left == 3'd0) ? PH_VSTART : PH_PREFIX;
                    end
                end
                PH_PREFIX: begin
                    prefix_left = prefix_left - 3'd1;
                    if (prefix_left == 3'd0) phase = PH_VSTART;
                end
                PH_VSTART: begin
                    if (b == CH_CR) begin
                        tag   = CL_EOL;
                        phase = PH_LINE_LF;
                    end else begin
                        tag   = CL_VERSION;
                        first = 1'b1;
                        phase = PH_VERSION;
                    end
                end
                PH_VERSION: begin
                    if (b == CH_CR) begin
                        tag   = CL_EOL;
                        phase = PH_LINE_LF;
                    end else begin
                        tag = CL_VERSION;
                    end
                end
                PH_LINE_LF: begin
                    if (b == CH_LF) begin
                        tag   = CL_EOL;
                        phase = PH_LINE_START;
                    end else begin
                        start_line(b, tag, first);
                    end
                end
                PH_LINE_START: start_line(b, tag, first);
                PH_NAME: begin
                    if (b == CH_COLON) phase = PH_HSEP;
                    else tag = CL_NAME;
                end
                PH_HSEP: begin
                    if (!(b == CH_COLON || is_blank(b) || b == CH_CR || b == CH_LF)) begin
                        tag   = CL_VALUE;
                        first = 1'b1;
                        phase = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (b == CH_CR) begin
                        tag   = CL_EOL;
                        phase = PH_LINE_LF;
                    end else begin
                        tag = CL_VALUE;
                    end
                end
                PH_END_LF: begin
                    tag   = CL_EOL;
                    phase = PH_BODY_FIRST;
                end
                PH_BODY_FIRST: begin
                    tag   = CL_BODY;
                    first = 1'b1;
                    phase = PH_BODY;
                end
                default: tag = CL_BODY;
            endcase
            e.byte_val = b;
            e.tag      = tag;
            e.first    = first;
            e.hdr_num  = hdr_count;
            expected_q.push_back(e);
        endfunction

        // accepted output item against the oldest expectation
        function void check_result(input logic [7:0] ob, input logic [2:0] bc,
                                   input logic tf, input logic [7:0] hn);
            t_exp_tag e;
            if (expected_q.size() == 0) begin
                $error("output item with nothing expected: out_byte %0h", ob);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (ob !== e.byte_val) begin
                $error("out_byte: expected %0h, got %0h", e.byte_val, ob);
                errors++;
            end
            if (bc !== e.tag) begin
                $error("byte_class: expected %0d, got %0d", e.tag, bc);
                errors++;
            end
            if (tf !== e.first) begin
                $error("token_first: expected %0d, got %0d", e.first, tf);
                errors++;
            end
            if (hn !== e.hdr_num) begin
                $error("header_number: expected %0d, got %0d", e.hdr_num, hn);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_data_byte;
    logic       i_new_request;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic [2:0] o_byte_class;
    logic       o_token_first;
    logic [7:0] o_header_number;

    token_scoreboard sb = new();

    logic [7:0]  req_bytes[$];
    int          burst_left;
    int          random_sent;
    int          cycle_count;
    t_stall_mode stall_mode;
    int          stall_left;
    int          stall_tick;

    http_request_byte_tokenizer #(
        .HEADER_COUNT_MAX(HDR_MAX)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_new_request  (i_new_request),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_class   (o_byte_class),
        .o_token_first  (o_token_first),
        .o_header_number(o_header_number)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stall pattern, switching to a randomly chosen behavior at random points
    initial begin
        i_out_stall = 1'b0;
        stall_left  = 0;
        stall_tick  = 0;
        stall_mode  = STALL_NONE;
    end
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 80);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= (stall_tick % 5 < 2);
        endcase
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_byte, o_byte_class, o_token_first, o_header_number);
        end
    end

    // printable-leaning byte that is no separator, blank or line end
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do begin
            b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(33, 126))
                                           : 8'($urandom_range(0, 255));
        end while (b == CH_CR || b == CH_LF || b == CH_SP || b == CH_TAB || b == CH_COLON);
        return b;
    endfunction

    function automatic logic [7:0] non_cr_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_CR);
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        return ($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB;
    endfunction

    // one input item, with burst gaps in front of it
    task automatic send_item(input logic [7:0] b, input logic restart);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_new_request <= restart;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(b, restart);
    endtask

    // request with random content, stray line ends and some missing lf bytes; compact lines are ":v<CR>"
    task automatic build_request(input int n_headers, input bit compact);
        int n;
        req_bytes.delete();
        repeat ($urandom_range(0, 2))
            req_bytes.push_back(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
        // method, possibly empty
        n = $urandom_range(0, 4);
        repeat (n) req_bytes.push_back(text_byte());
        repeat ($urandom_range(1, 2)) req_bytes.push_back(blank_byte());
        // uri
        n = $urandom_range(1, 6);
        repeat (n) req_bytes.push_back(text_byte());
        repeat ($urandom_range(1, 2)) req_bytes.push_back(blank_byte());
        // skipped prefix: first one must leave the separators
        req_bytes.push_back(text_byte());
        repeat (PREFIX_LEN - 1) req_bytes.push_back(8'($urandom_range(0, 255)));
        // version, possibly empty
        n = $urandom_range(0, 4);
        repeat (n) req_bytes.push_back(non_cr_byte());
        req_bytes.push_back(CH_CR);
        if ($urandom_range(0, 7) != 0) req_bytes.push_back(CH_LF);
        // header lines
        repeat (n_headers) begin
            if (compact) begin
                req_bytes.push_back(CH_COLON);
                req_bytes.push_back(text_byte());
                req_bytes.push_back(CH_CR);
            end else begin
                if ($urandom_range(0, 7) != 0) begin
                    req_bytes.push_back(text_byte());
                    repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 5) == 0)
                            req_bytes.push_back(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
                        else
                            req_bytes.push_back(text_byte());
                    end
                end
                req_bytes.push_back(CH_COLON);
                repeat ($urandom_range(0, 2)) begin
                    case ($urandom_range(0, 4))
                        0:       req_bytes.push_back(CH_COLON);
                        1:       req_bytes.push_back(CH_CR);
                        2:       req_bytes.push_back(CH_LF);
                        default: req_bytes.push_back(blank_byte());
                    endcase
                end
                req_bytes.push_back(text_byte());
                repeat ($urandom_range(0, 4)) req_bytes.push_back(non_cr_byte());
                req_bytes.push_back(CH_CR);
                if ($urandom_range(0, 7) != 0) req_bytes.push_back(CH_LF);
            end
        end
        // end of headers, then body
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(($urandom_range(0, 7) != 0) ? CH_LF : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 8)) req_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // send the built request, sometimes cut short or without the restart flag
    task automatic send_request(output int sent);
        int  stop;
        bit  restart;
        stop    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, req_bytes.size())
                                              : req_bytes.size();
        restart = ($urandom_range(0, 7) != 0);
        for (int k = 0; k < stop; k++) begin
            send_item(req_bytes[k], restart && k == 0);
        end
        sent = stop;
    endtask

    logic [7:0] directed_bytes[25] = '{
        CH_CR, CH_LF, CH_SP, 8'h55, CH_TAB, CH_CR, 8'h00, 8'hFF, CH_SP, CH_COLON,
        CH_CR, 8'h41, CH_CR, CH_LF, CH_COLON, CH_SP, 8'h76, CH_CR, CH_COLON, 8'h80,
        CH_CR, CH_CR, 8'hFF, 8'h00, 8'h47
    };

    initial begin
        int sent;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_byte   = 8'h00;
        i_new_request = 1'b0;
        burst_left    = 0;
        random_sent   = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: blank at start, prefix with cr, empty version, cr in name,
        // colon at line start, cr after cr, end of headers with any byte, body, restart
        for (int k = 0; k < 25; k++) begin
            send_item(directed_bytes[k], k == 0 || k == 24);
        end

        // enough header lines to saturate the count
        build_request(HDR_CAP + 5, 1'b1);
        for (int k = 0; k < req_bytes.size(); k++) begin
            send_item(req_bytes[k], k == 0);
        end

        // random requests mixed with noise
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                    random_sent++;
                end
            end else begin
                build_request($urandom_range(0, 5), 1'b0);
                send_request(sent);
                random_sent += sent;
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
